/* rtl/ptwa_pkg.sv */
`timescale 1ns / 1ps

package ptwa_pkg;

   // table geometry
   localparam int unsigned ENTRIES = 32;
   localparam int unsigned IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int unsigned CNT_W   = $clog2(ENTRIES + 1);

   // field widths
   localparam int unsigned ADDR_W   = 32;
   localparam int unsigned TIME_W   = 32;
   localparam int unsigned AGE_W    = 16;
   localparam int unsigned SLOT_W   = 8;
   localparam int unsigned STATUS_W = 3;
   localparam int unsigned OP_W     = 2;
   localparam int unsigned CSR_IX_W = 2;
   localparam int unsigned CSR_D_W  = 32;

   // opcodes
   localparam logic [OP_W-1:0] OP_OBSERVE = 2'd0;
   localparam logic [OP_W-1:0] OP_TICK    = 2'd1;
   localparam logic [OP_W-1:0] OP_LIST    = 2'd2;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_REFRESHED = 3'd0;
   localparam logic [STATUS_W-1:0] ST_ADDED     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_OWN       = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
   localparam logic [STATUS_W-1:0] ST_LISTED    = 3'd4;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd5;

   // register indexes
   localparam logic [CSR_IX_W-1:0] CSR_LOCAL_ADDRESS = 2'd0;
   localparam logic [CSR_IX_W-1:0] CSR_KEEP_OWN      = 2'd1;
   localparam logic [CSR_IX_W-1:0] CSR_MAX_AGE       = 2'd2;

   // reset values
   localparam logic [ADDR_W-1:0] LOCAL_ADDRESS_RST = '0;
   localparam logic              KEEP_OWN_RST      = 1'b1;
   localparam logic [AGE_W-1:0]  MAX_AGE_RST       = 16'd30;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_FINISH
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic accept;  // input beat taken
      logic start;   // begin a table scan
      logic step;    // advance the scan pipeline
      logic finish;  // close the item, push final result
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic req_scan;   // offered item needs a scan
      logic scan_done;  // all slots read and checked
      logic chk_push;   // check stage must push a result
      logic out_free;   // output register can take a beat
   } sts_type;

endpackage

/* rtl/ptwa_ctrl.sv */
`timescale 1ns / 1ps

module ptwa_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ptwa_pkg::sts_type sts,
   output ptwa_pkg::cmd_type cmd
);

   ptwa_pkg::state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ptwa_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_ready  = 1'b0;
      unique case (state_ff)
         ptwa_pkg::S_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
            cmd.start  = req_valid & sts.req_scan;
            if (cmd.start) begin
               state_in = ptwa_pkg::S_SCAN;
            end
         end
         ptwa_pkg::S_SCAN: begin
            if (sts.scan_done) begin
               state_in = ptwa_pkg::S_FINISH;
            end else begin
               // hold the pipeline while a result waits for the output
               cmd.step = !sts.chk_push || sts.out_free;
            end
         end
         ptwa_pkg::S_FINISH: begin
            cmd.finish = sts.out_free;
            if (sts.out_free) begin
               state_in = ptwa_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = ptwa_pkg::S_IDLE;
         end
      endcase
   end

endmodule

/* rtl/ptwa_dp.sv */
`timescale 1ns / 1ps

module ptwa_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  ptwa_pkg::cmd_type                   cmd,
   output ptwa_pkg::sts_type                   sts,
   input  logic [ptwa_pkg::OP_W-1:0]           req_opcode,
   input  logic [ptwa_pkg::ADDR_W-1:0]         req_source_address,
   input  logic                                csr_we,
   input  logic [ptwa_pkg::CSR_IX_W-1:0]       csr_index,
   input  logic [ptwa_pkg::CSR_D_W-1:0]        csr_wdata,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic [ptwa_pkg::STATUS_W-1:0]       rsp_status,
   output logic [ptwa_pkg::ADDR_W-1:0]         rsp_entry_address,
   output logic [ptwa_pkg::SLOT_W-1:0]         rsp_entry_slot,
   output logic [ptwa_pkg::AGE_W-1:0]          rsp_entry_age,
   output logic                                rsp_last
);

   localparam int unsigned N   = ptwa_pkg::ENTRIES;
   localparam int unsigned IW  = ptwa_pkg::IDX_W;
   localparam int unsigned CW  = ptwa_pkg::CNT_W;
   localparam int unsigned AW  = ptwa_pkg::ADDR_W;
   localparam int unsigned TW  = ptwa_pkg::TIME_W;
   localparam int unsigned GW  = ptwa_pkg::AGE_W;

   // configuration and clock of the table
   logic [AW-1:0] local_address_ff;
   logic          keep_own_ff;
   logic [GW-1:0] max_age_ff;
   logic [TW-1:0] now_ff;

   // slot store: valid bits in flops, address and time in memory
   logic [N-1:0]  valid_ff;
   logic [AW-1:0] mem_addr [N];
   logic [TW-1:0] mem_time [N];
   logic [AW-1:0] rd_addr_ff;
   logic [TW-1:0] rd_time_ff;

   // item and scan state
   logic [ptwa_pkg::OP_W-1:0] op_ff;
   logic [AW-1:0]             src_ff;
   logic [CW-1:0]             issue_ff;
   logic                      chk_v_ff;
   logic [IW-1:0]             chk_idx_ff;
   logic                      hit_ff, free_ff;
   logic [IW-1:0]             hit_idx_ff, free_idx_ff;

   // held list result, so the final one can carry last
   logic          pend_v_ff;
   logic [AW-1:0] pend_addr_ff;
   logic [IW-1:0] pend_idx_ff;
   logic [GW-1:0] pend_age_ff;

   // output register
   logic                          rsp_valid_ff;
   logic [ptwa_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [AW-1:0]                 rsp_addr_ff, rsp_addr_in;
   logic [ptwa_pkg::SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic [GW-1:0]                 rsp_age_ff, rsp_age_in;
   logic                          rsp_last_ff, rsp_last_in;
   logic                          out_load;

   logic          issue_live;
   logic [IW-1:0] rd_idx;
   logic          is_obs, is_list, own;
   logic          chk_valid, survive, chk_surv;
   logic [TW-1:0] age_full;
   logic          do_add, do_refresh;
   logic [IW-1:0] wr_idx;

   // scan status
   assign issue_live = issue_ff != CW'(N);
   assign rd_idx     = issue_ff[IW-1:0];
   assign is_obs     = op_ff == ptwa_pkg::OP_OBSERVE;
   assign is_list    = op_ff == ptwa_pkg::OP_LIST;
   assign own        = (src_ff == local_address_ff) && !keep_own_ff;

   // check stage: one slot per cycle while the scan is not held
   assign chk_valid = valid_ff[chk_idx_ff];
   assign age_full  = now_ff - rd_time_ff;
   assign survive   = age_full <= TW'(max_age_ff);
   assign chk_surv  = chk_v_ff && is_list && chk_valid && survive;

   assign sts.req_scan  = (req_opcode == ptwa_pkg::OP_OBSERVE) ||
                          (req_opcode == ptwa_pkg::OP_LIST);
   assign sts.scan_done = !issue_live && !chk_v_ff;
   assign sts.chk_push  = chk_surv && pend_v_ff;
   assign sts.out_free  = !rsp_valid_ff || rsp_ready;

   // observe write-back at the end of the scan
   assign do_refresh = cmd.finish && is_obs && !own && hit_ff;
   assign do_add     = cmd.finish && is_obs && !own && !hit_ff && free_ff;
   assign wr_idx     = hit_ff ? hit_idx_ff : free_idx_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         local_address_ff <= ptwa_pkg::LOCAL_ADDRESS_RST;
         keep_own_ff      <= ptwa_pkg::KEEP_OWN_RST;
         max_age_ff       <= ptwa_pkg::MAX_AGE_RST;
         now_ff           <= '0;
         valid_ff         <= '0;
         issue_ff         <= '0;
         chk_v_ff         <= 1'b0;
         hit_ff           <= 1'b0;
         free_ff          <= 1'b0;
         pend_v_ff        <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               ptwa_pkg::CSR_LOCAL_ADDRESS: local_address_ff <= csr_wdata[AW-1:0];
               ptwa_pkg::CSR_KEEP_OWN:      keep_own_ff      <= csr_wdata[0];
               ptwa_pkg::CSR_MAX_AGE:       max_age_ff       <= csr_wdata[GW-1:0];
               default: ;
            endcase
         end
         if (cmd.accept && (req_opcode == ptwa_pkg::OP_TICK)) begin
            now_ff <= now_ff + TW'(1);
         end
         if (cmd.start) begin
            issue_ff  <= '0;
            chk_v_ff  <= 1'b0;
            hit_ff    <= 1'b0;
            free_ff   <= 1'b0;
            pend_v_ff <= 1'b0;
         end
         if (cmd.step) begin
            if (issue_live) begin
               issue_ff <= issue_ff + CW'(1);
            end
            chk_v_ff <= issue_live;
            if (chk_v_ff) begin
               if (is_obs) begin
                  if (!hit_ff && chk_valid && (rd_addr_ff == src_ff)) begin
                     hit_ff <= 1'b1;
                  end
                  if (!free_ff && !chk_valid) begin
                     free_ff <= 1'b1;
                  end
               end
               if (is_list && chk_valid && !survive) begin
                  valid_ff[chk_idx_ff] <= 1'b0;
               end
               if (chk_surv) begin
                  pend_v_ff <= 1'b1;
               end
            end
         end
         if (do_add) begin
            valid_ff[free_idx_ff] <= 1'b1;
         end
         if (cmd.finish) begin
            pend_v_ff <= 1'b0;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers of the scan
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         op_ff  <= req_opcode;
         src_ff <= req_source_address;
      end
      if (cmd.step) begin
         chk_idx_ff <= rd_idx;
         if (chk_v_ff && is_obs) begin
            if (!hit_ff && chk_valid && (rd_addr_ff == src_ff)) begin
               hit_idx_ff <= chk_idx_ff;
            end
            if (!free_ff && !chk_valid) begin
               free_idx_ff <= chk_idx_ff;
            end
         end
         if (chk_surv) begin
            pend_addr_ff <= rd_addr_ff;
            pend_idx_ff  <= chk_idx_ff;
            pend_age_ff  <= age_full[GW-1:0];
         end
      end
   end

   // slot memory, registered read
   always_ff @(posedge clock) begin
      if (do_refresh || do_add) begin
         mem_time[wr_idx] <= now_ff;
      end
      if (do_add) begin
         mem_addr[wr_idx] <= src_ff;
      end
      if (cmd.step && issue_live) begin
         rd_addr_ff <= mem_addr[rd_idx];
         rd_time_ff <= mem_time[rd_idx];
      end
   end

   // result selection
   always_comb begin
      out_load      = 1'b0;
      rsp_status_in = ptwa_pkg::ST_EMPTY;
      rsp_addr_in   = '0;
      rsp_slot_in   = '0;
      rsp_age_in    = '0;
      rsp_last_in   = 1'b1;
      priority if (cmd.step && sts.chk_push) begin
         // a newer survivor arrived: release the held one
         out_load      = 1'b1;
         rsp_status_in = ptwa_pkg::ST_LISTED;
         rsp_addr_in   = pend_addr_ff;
         rsp_slot_in   = ptwa_pkg::SLOT_W'(pend_idx_ff);
         rsp_age_in    = pend_age_ff;
         rsp_last_in   = 1'b0;
      end else if (cmd.finish) begin
         out_load = 1'b1;
         if (is_obs) begin
            rsp_addr_in = src_ff;
            priority if (own) begin
               rsp_status_in = ptwa_pkg::ST_OWN;
            end else if (hit_ff) begin
               rsp_status_in = ptwa_pkg::ST_REFRESHED;
               rsp_slot_in   = ptwa_pkg::SLOT_W'(hit_idx_ff);
            end else if (free_ff) begin
               rsp_status_in = ptwa_pkg::ST_ADDED;
               rsp_slot_in   = ptwa_pkg::SLOT_W'(free_idx_ff);
            end else begin
               rsp_status_in = ptwa_pkg::ST_FULL;
            end
         end else if (pend_v_ff) begin
            rsp_status_in = ptwa_pkg::ST_LISTED;
            rsp_addr_in   = pend_addr_ff;
            rsp_slot_in   = ptwa_pkg::SLOT_W'(pend_idx_ff);
            rsp_age_in    = pend_age_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_addr_ff   <= rsp_addr_in;
         rsp_slot_ff   <= rsp_slot_in;
         rsp_age_ff    <= rsp_age_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_entry_address = rsp_addr_ff;
   assign rsp_entry_slot    = rsp_slot_ff;
   assign rsp_entry_age     = rsp_age_ff;
   assign rsp_last          = rsp_last_ff;

endmodule

/* rtl/peer_table_with_aging.sv */
`timescale 1ns / 1ps
// Peer table with aging.
// Request channel (req_valid/req_ready, req_opcode, req_source_address):
//   observe, tick or list beats. Response channel (rsp_valid/rsp_ready):
//   status, entry address, slot, age and a last flag per beat.
// Configuration (csr_we, csr_index, csr_wdata): local address, keep-own
//   flag and maximum age, written with no handshake.
// Tick beats are taken from idle without a scan and give no response.
// Observe and list beats scan every slot through a single registered read
//   port of the slot memory, one slot a cycle while the receiver keeps up;
//   the next beat is taken only after an item's final response is loaded.
//   Observe gives one response; list gives one per surviving slot, or one
//   empty-list beat.
// A list response is held one slot back so that the final one carries
//   last; a stalled receiver freezes the scan, nothing is dropped.
// req_ready is high only between items; the output register lets a new
//   item start while the previous final response still waits.
// Synchronous reset clears all valid bits, the seconds counter and the
//   configuration to its defaults; no clearing pass is needed.

module peer_table_with_aging (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [ptwa_pkg::OP_W-1:0]     req_opcode,
   input  logic [ptwa_pkg::ADDR_W-1:0]   req_source_address,
   input  logic                          csr_we,
   input  logic [ptwa_pkg::CSR_IX_W-1:0] csr_index,
   input  logic [ptwa_pkg::CSR_D_W-1:0]  csr_wdata,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [ptwa_pkg::STATUS_W-1:0] rsp_status,
   output logic [ptwa_pkg::ADDR_W-1:0]   rsp_entry_address,
   output logic [ptwa_pkg::SLOT_W-1:0]   rsp_entry_slot,
   output logic [ptwa_pkg::AGE_W-1:0]    rsp_entry_age,
   output logic                          rsp_last
);

   ptwa_pkg::cmd_type cmd;
   ptwa_pkg::sts_type sts;

   ptwa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   ptwa_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_opcode         (req_opcode),
      .req_source_address (req_source_address),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .rsp_ready          (rsp_ready),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_entry_address  (rsp_entry_address),
      .rsp_entry_slot     (rsp_entry_slot),
      .rsp_entry_age      (rsp_entry_age),
      .rsp_last           (rsp_last)
   );

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
   import ptwa_pkg::*;

   // opcode and register index that the block must ignore
   localparam logic [OP_W-1:0]     OP_UNUSED  = 2'd3;
   localparam logic [CSR_IX_W-1:0] CSR_UNUSED = 2'd3;

   localparam int POOL_SIZE      = 40;
   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int DIRECTED_ROWS  = 22;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ADDR_W-1:0]   address;
      logic [SLOT_W-1:0]   slot;
      logic [AGE_W-1:0]    age;
      logic                last;
   } peer_beat_type;

   typedef enum logic {ROW_REQ, ROW_CSR} row_kind_type;

   // one line of the directed script: a request beat or a register write
   typedef struct {
      row_kind_type  kind;
      logic [1:0]    code;
      logic [31:0]   data;
      bit            typed;
      peer_beat_type want;
   } script_row_type;

   logic                clock;
   logic                reset              = 1'b1;
   logic                req_valid          = 1'b0;
   logic                req_ready;
   logic [OP_W-1:0]     req_opcode         = OP_TICK;
   logic [ADDR_W-1:0]   req_source_address = '0;
   logic                csr_we             = 1'b0;
   logic [CSR_IX_W-1:0] csr_index          = CSR_LOCAL_ADDRESS;
   logic [CSR_D_W-1:0]  csr_wdata          = '0;
   logic                rsp_valid;
   logic                rsp_ready          = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [ADDR_W-1:0]   rsp_entry_address;
   logic [SLOT_W-1:0]   rsp_entry_slot;
   logic [AGE_W-1:0]    rsp_entry_age;
   logic                rsp_last;

   // shadow of the peer table and its registers
   logic [ADDR_W-1:0] cfg_local    = LOCAL_ADDRESS_RST;
   logic              cfg_keep_own = KEEP_OWN_RST;
   logic [AGE_W-1:0]  cfg_max_age  = MAX_AGE_RST;
   bit                tbl_valid [ENTRIES];
   logic [ADDR_W-1:0] tbl_addr  [ENTRIES];
   logic [TIME_W-1:0] tbl_seen  [ENTRIES];
   logic [TIME_W-1:0] secs_now = '0;

   peer_beat_type     replies_due [$];
   peer_beat_type     got_beat;
   peer_beat_type     due_beat;
   logic [ADDR_W-1:0] addr_pool [POOL_SIZE];
   script_row_type    directed_rows [DIRECTED_ROWS];

   int errors        = 0;
   int send_idle_pct = 0;
   int rcv_stall_pct = 0;
   int hold_seq      = 0;
   int hold_seen     = 0;
   int hold_left     = 0;
   int quiet_cycles  = 0;

   peer_table_with_aging u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_opcode         (req_opcode),
      .req_source_address (req_source_address),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_entry_address  (rsp_entry_address),
      .rsp_entry_slot     (rsp_entry_slot),
      .rsp_entry_age      (rsp_entry_age),
      .rsp_last           (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // work out the response beats one request causes, updating the shadow table
   function automatic void predict_replies(input logic [OP_W-1:0] op,
                                           input logic [ADDR_W-1:0] addr,
                                           output peer_beat_type beats [$]);
      int            hit;
      int            free;
      bit            held_ok;
      logic [TIME_W-1:0] age;
      peer_beat_type b;
      peer_beat_type held;
      b       = '{ST_OWN, addr, '0, '0, 1'b1};
      held    = '0;
      held_ok = 1'b0;
      hit     = -1;
      free    = -1;
      case (op)
         OP_OBSERVE: begin
            if (!(addr == cfg_local && !cfg_keep_own)) begin
               for (int i = 0; i < ENTRIES; i++) begin
                  if (hit < 0 && tbl_valid[i] && tbl_addr[i] == addr) hit = i;
                  if (free < 0 && !tbl_valid[i]) free = i;
               end
               if (hit >= 0) begin
                  tbl_seen[hit] = secs_now;
                  b.status      = ST_REFRESHED;
                  b.slot        = SLOT_W'(hit);
               end else if (free >= 0) begin
                  tbl_valid[free] = 1'b1;
                  tbl_addr[free]  = addr;
                  tbl_seen[free]  = secs_now;
                  b.status        = ST_ADDED;
                  b.slot          = SLOT_W'(free);
               end else begin
                  b.status = ST_FULL;
               end
            end
            beats.push_back(b);
         end
         OP_TICK: secs_now = secs_now + TIME_W'(1);
         OP_LIST: begin
            // each survivor is held back one slot so the final one gets last
            for (int i = 0; i < ENTRIES; i++) begin
               if (tbl_valid[i]) begin
                  age = secs_now - tbl_seen[i];
                  if (age > TIME_W'(cfg_max_age)) begin
                     tbl_valid[i] = 1'b0;
                  end else begin
                     if (held_ok) beats.push_back(held);
                     held    = '{ST_LISTED, tbl_addr[i], SLOT_W'(i), age[AGE_W-1:0], 1'b0};
                     held_ok = 1'b1;
                  end
               end
            end
            if (held_ok) begin
               held.last = 1'b1;
               beats.push_back(held);
            end else begin
               beats.push_back('{ST_EMPTY, '0, '0, '0, 1'b1});
            end
         end
         default: ;  // unused opcode: no beat, no state change
      endcase
   endfunction

   task automatic send_request(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr,
                               input bit typed, input peer_beat_type want);
      peer_beat_type produced [$];
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_opcode         <= op;
      req_source_address <= addr;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_replies(op, addr, produced);
      if (typed) replies_due.push_back(want);
      else foreach (produced[k]) replies_due.push_back(produced[k]);
   endtask

   // sender stops until every response is back, then lets a scan run out
   task automatic settle_block();
      req_valid <= 1'b0;
      while (replies_due.size() != 0) @(posedge clock);
      repeat (ENTRIES + 8) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IX_W-1:0] idx, input logic [CSR_D_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         CSR_LOCAL_ADDRESS: cfg_local    = data[ADDR_W-1:0];
         CSR_KEEP_OWN:      cfg_keep_own = data[0];
         CSR_MAX_AGE:       cfg_max_age  = data[AGE_W-1:0];
         default: ;  // unknown index, write dropped
      endcase
   endtask

   // observes, mostly of known peers, with ticks, listings and some noise
   task automatic pick_request(output logic [OP_W-1:0] op, output logic [ADDR_W-1:0] addr);
      int r;
      r    = $urandom_range(99);
      addr = $urandom();
      if (r < 50) begin
         op = OP_OBSERVE;
         case ($urandom_range(9))
            0:       addr = cfg_local;
            1:       ;
            default: addr = addr_pool[$urandom_range(POOL_SIZE - 1)];
         endcase
      end else if (r < 78) begin
         op = OP_TICK;
      end else if (r < 95) begin
         op = OP_LIST;
      end else begin
         op = OP_UNUSED;
      end
   endtask

   task automatic run_phase(input int s_idle, input int r_stall,
                            input logic [ADDR_W-1:0] local_addr, input bit keep,
                            input logic [AGE_W-1:0] age_limit, input int n_reqs,
                            input bit fill_first, input bit long_hold);
      logic [OP_W-1:0]   op;
      logic [ADDR_W-1:0] addr;
      settle_block();
      csr_write(CSR_LOCAL_ADDRESS, local_addr);
      csr_write(CSR_KEEP_OWN, {31'($urandom()), keep});
      csr_write(CSR_MAX_AGE, {16'($urandom()), age_limit});
      csr_we        <= 1'b0;
      send_idle_pct = s_idle;
      rcv_stall_pct = r_stall;
      // fill every free slot and run past the end of the table
      if (fill_first) begin
         for (int k = 0; k < ENTRIES + 2; k++) send_request(OP_OBSERVE, addr_pool[k], 1'b0, '0);
         send_request(OP_LIST, '0, 1'b0, '0);
      end
      for (int k = 0; k < n_reqs; k++) begin
         if (long_hold && k == 8) hold_seq++;
         pick_request(op, addr);
         send_request(op, addr, 1'b0, '0);
      end
   endtask

   // stimulus
   initial begin
      foreach (addr_pool[k]) addr_pool[k] = $urandom();
      foreach (tbl_valid[k]) begin
         tbl_valid[k] = 1'b0;
         tbl_addr[k]  = '0;
         tbl_seen[k]  = '0;
      end
      directed_rows = '{
         // empty table after reset, then own address taken while keep-own is set
         '{ROW_REQ, OP_LIST,     32'h0,        1'b1, '{ST_EMPTY,     32'h0,        8'd0, 16'd0, 1'b1}},
         '{ROW_REQ, OP_OBSERVE,  32'h00000000, 1'b1, '{ST_ADDED,     32'h00000000, 8'd0, 16'd0, 1'b1}},
         '{ROW_REQ, OP_OBSERVE,  32'hFFFFFFFF, 1'b1, '{ST_ADDED,     32'hFFFFFFFF, 8'd1, 16'd0, 1'b1}},
         '{ROW_REQ, OP_OBSERVE,  32'h00000000, 1'b1, '{ST_REFRESHED, 32'h00000000, 8'd0, 16'd0, 1'b1}},
         '{ROW_REQ, OP_TICK,     32'h5A5A5A5A, 1'b0, '0},
         '{ROW_REQ, OP_UNUSED,   32'hFFFFFFFF, 1'b0, '0},
         '{ROW_REQ, OP_LIST,     32'h0,        1'b0, '0},
         // own address dropped once keep-own is cleared
         '{ROW_CSR, CSR_LOCAL_ADDRESS, 32'hC0A80001, 1'b0, '0},
         '{ROW_CSR, CSR_KEEP_OWN,      32'hFFFFFFFE, 1'b0, '0},
         '{ROW_REQ, OP_OBSERVE,  32'hC0A80001, 1'b1, '{ST_OWN,       32'hC0A80001, 8'd0, 16'd0, 1'b1}},
         '{ROW_REQ, OP_OBSERVE,  32'h00000000, 1'b1, '{ST_REFRESHED, 32'h00000000, 8'd0, 16'd0, 1'b1}},
         // zero max age: only slots seen this second survive
         '{ROW_CSR, CSR_UNUSED,        32'hFFFFFFFF, 1'b0, '0},
         '{ROW_CSR, CSR_MAX_AGE,       32'hFFFF0000, 1'b0, '0},
         '{ROW_REQ, OP_TICK,     32'h0,        1'b0, '0},
         '{ROW_REQ, OP_OBSERVE,  32'h0A000001, 1'b1, '{ST_ADDED,     32'h0A000001, 8'd2, 16'd0, 1'b1}},
         '{ROW_REQ, OP_LIST,     32'h0,        1'b1, '{ST_LISTED,    32'h0A000001, 8'd2, 16'd0, 1'b1}},
         '{ROW_REQ, OP_TICK,     32'h0,        1'b0, '0},
         '{ROW_REQ, OP_LIST,     32'h0,        1'b1, '{ST_EMPTY,     32'h0,        8'd0, 16'd0, 1'b1}},
         // widest max age, keep-own back on
         '{ROW_CSR, CSR_MAX_AGE,       32'h0000FFFF, 1'b0, '0},
         '{ROW_CSR, CSR_KEEP_OWN,      32'h00000001, 1'b0, '0},
         '{ROW_REQ, OP_OBSERVE,  32'hC0A80001, 1'b1, '{ST_ADDED,     32'hC0A80001, 8'd0, 16'd0, 1'b1}},
         '{ROW_REQ, OP_LIST,     32'h0,        1'b0, '0}
      };

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[k]) begin
         if (directed_rows[k].kind == ROW_CSR) begin
            settle_block();
            csr_write(directed_rows[k].code, directed_rows[k].data);
            csr_we <= 1'b0;
         end else begin
            send_request(directed_rows[k].code, directed_rows[k].data,
                         directed_rows[k].typed, directed_rows[k].want);
         end
      end

      run_phase(0,  0,  $urandom(),   1'b1, 16'hFFFF, 40, 1'b1, 1'b0);
      run_phase(47, 0,  32'hFFFFFFFF, 1'b0, 16'd1,    50, 1'b0, 1'b0);
      run_phase(0,  47, addr_pool[3], 1'b1, 16'd4,    50, 1'b0, 1'b1);
      run_phase(35, 35, addr_pool[5], 1'b0, 16'd2,    45, 1'b0, 1'b0);

      req_valid <= 1'b0;
      while (replies_due.size() != 0) @(posedge clock);
      repeat (2 * ENTRIES + 8) @(posedge clock);
      if (errors == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

   task automatic flag_field(input string name, input logic [31:0] want, input logic [31:0] got);
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
   endtask

   // response side: check each beat, then pick ready for the next cycle
   always @(posedge clock) begin
      if (rsp_valid && rsp_ready) begin
         got_beat = '{rsp_status, rsp_entry_address, rsp_entry_slot, rsp_entry_age, rsp_last};
         if (replies_due.size() == 0) begin
            errors++;
            $display("%0t: expected no beat, actual status %0d address %0h",
                     $time, got_beat.status, got_beat.address);
         end else begin
            due_beat = replies_due.pop_front();
            if (got_beat.status !== due_beat.status)
               flag_field("status", 32'(due_beat.status), 32'(got_beat.status));
            if (got_beat.address !== due_beat.address)
               flag_field("entry_address", due_beat.address, got_beat.address);
            if (got_beat.slot !== due_beat.slot)
               flag_field("entry_slot", 32'(due_beat.slot), 32'(got_beat.slot));
            if (got_beat.age !== due_beat.age)
               flag_field("entry_age", 32'(due_beat.age), 32'(got_beat.age));
            if (got_beat.last !== due_beat.last)
               flag_field("last", 32'(due_beat.last), 32'(got_beat.last));
         end
      end
      // long back-pressure stretch, counted here while the sender keeps going
      if (hold_seq != hold_seen) begin
         hold_seen = hold_seq;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rcv_stall_pct);
      end
   end

   // watchdog: cycles with no beat on either channel
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog, no beat for %0d cycles", $time, quiet_cycles);
         $display("DONE: errors detected");
         $finish;
      end
   end

endmodule
